FILE: rtl/core/ostc_pkg.sv
// shared types and constants of the opening tag syntax checker
package ostc_pkg;

  localparam int unsigned CpWidth = 21;
  localparam int unsigned QDepth  = 2;  // power of two, pointers wrap naturally

  // character classes decoded once at the input
  typedef struct packed {
    logic ws;       // space, tab, lf, vt, ff, cr
    logic space;    // plain space only
    logic alpha;    // ascii letter
    logic lt;
    logic gt;
    logic slash;
    logic eq;
    logic sq;
    logic dq;
    logic bq;
    logic ctrl_nc;  // control or noncharacter
  } ostc_class_t;

  typedef struct packed {
    ostc_class_t cls;
    logic        last;
  } ostc_item_t;

  // back end status seen by the top level
  typedef struct packed {
    logic       pop;
    logic       last;
    logic [3:0] err;
  } ostc_stat_t;

endpackage

FILE: rtl/core/ostc_front.sv
// front end: accepts code points, decodes their class and queues them
module ostc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,   // code_point[20:0], zero fill
  input  logic                s_axis_tlast,   // is_last
  output logic                q_valid_o,
  output ostc_pkg::ostc_item_t q_item_o,
  input  logic                q_pop_i
);
  import ostc_pkg::*;

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  logic [CpWidth-1:0] cp;
  ostc_item_t         item_in;
  ostc_item_t         mem_q [QDepth];
  logic [PtrW-1:0]    wptr_q, rptr_q;
  logic [CntW-1:0]    cnt_q;
  logic               push;

  assign cp = s_axis_tdata[CpWidth-1:0];

  always_comb begin
    item_in.last          = s_axis_tlast;
    item_in.cls.ws        = (cp == 21'h20) || (cp >= 21'h09 && cp <= 21'h0D);
    item_in.cls.space     = (cp == 21'h20);
    item_in.cls.alpha     = (cp >= 21'h41 && cp <= 21'h5A) || (cp >= 21'h61 && cp <= 21'h7A);
    item_in.cls.lt        = (cp == 21'h3C);
    item_in.cls.gt        = (cp == 21'h3E);
    item_in.cls.slash     = (cp == 21'h2F);
    item_in.cls.eq        = (cp == 21'h3D);
    item_in.cls.sq        = (cp == 21'h27);
    item_in.cls.dq        = (cp == 21'h22);
    item_in.cls.bq        = (cp == 21'h60);
    item_in.cls.ctrl_nc   = (cp < 21'h20) || (cp >= 21'h7F && cp <= 21'h9F) ||
                            (cp > 21'h10FFFF) || (cp >= 21'hFDD0 && cp <= 21'hFDEF) ||
                            (cp[15:1] == 15'h7FFF);
  end

  assign s_axis_tready = (cnt_q != CntW'(QDepth));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid_o     = (cnt_q != '0);
  assign q_item_o      = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + PtrW'(1);
      if (q_pop_i) rptr_q <= rptr_q + PtrW'(1);
      if (push && !q_pop_i) cnt_q <= cnt_q + CntW'(1);
      else if (!push && q_pop_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

FILE: rtl/core/ostc_back.sv
// back end: tag state machine, counters and output register
module ostc_back #(
  parameter int unsigned MAX_NAME_LEN = 255,
  parameter int unsigned MAX_ATTRS    = 63
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  ostc_pkg::ostc_item_t q_item_i,
  output logic                 q_pop_o,
  output ostc_pkg::ostc_stat_t stat_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata, // role[1:0], attr_number[7:2],
                                             // error_code[11:8], self_closing[12],
                                             // name_length[20:13], attr_count[26:21]
  output logic                 m_axis_tlast  // done_res
);
  import ostc_pkg::*;

  localparam int unsigned NW = $clog2(MAX_NAME_LEN + 1);
  localparam int unsigned AW = $clog2(MAX_ATTRS + 1);

  localparam logic [3:0] PhOpen      = 4'd0;
  localparam logic [3:0] PhNameFirst = 4'd1;
  localparam logic [3:0] PhName      = 4'd2;
  localparam logic [3:0] PhGap       = 4'd3;
  localparam logic [3:0] PhAttrName  = 4'd4;
  localparam logic [3:0] PhAfterName = 4'd5;
  localparam logic [3:0] PhValStart  = 4'd6;
  localparam logic [3:0] PhUnquoted  = 4'd7;
  localparam logic [3:0] PhQuoted    = 4'd8;
  localparam logic [3:0] PhSlash     = 4'd9;
  localparam logic [3:0] PhClosed    = 4'd10;
  localparam logic [3:0] PhFailed    = 4'd11;

  localparam logic [3:0] ErrNone     = 4'd0;
  localparam logic [3:0] ErrStart    = 4'd1;
  localparam logic [3:0] ErrName     = 4'd2;
  localparam logic [3:0] ErrAttrName = 4'd3;
  localparam logic [3:0] ErrNoValue  = 4'd4;
  localparam logic [3:0] ErrValChar  = 4'd5;
  localparam logic [3:0] ErrUnclosed = 4'd6;
  localparam logic [3:0] ErrNoEnd    = 4'd7;
  localparam logic [3:0] ErrSelfCl   = 4'd8;
  localparam logic [3:0] ErrTrailing = 4'd9;

  localparam logic [1:0] RoleStruct  = 2'd0;
  localparam logic [1:0] RoleTagName = 2'd1;
  localparam logic [1:0] RoleAttrNm  = 2'd2;
  localparam logic [1:0] RoleAttrVal = 2'd3;

  localparam logic [1:0] QkNone   = 2'd0;
  localparam logic [1:0] QkSingle = 2'd1;
  localparam logic [1:0] QkDouble = 2'd2;

  function automatic logic [3:0] keep_first(input logic [3:0] cur, input logic [3:0] code);
    keep_first = (cur == ErrNone) ? code : cur;
  endfunction

  logic [3:0]    ph_q, ph_d, err_q, err_d;
  logic [1:0]    qk_q, qk_d;
  logic [NW-1:0] nc_q, nc_d;
  logic [AW-1:0] ac_q, ac_d;
  logic          sl_q, sl_d;
  logic          ov_q, ov_d;
  logic [31:0]   data_q, data_d;
  logic          last_q;

  logic [3:0]    ph, err;
  logic [1:0]    qk, role;
  logic [NW-1:0] nc;
  logic [AW-1:0] ac, idx;
  logic          sl, self_cl;
  logic          ends, nbad, ubad;
  logic [AW+5:0] idx_x, ac_x;
  logic [NW+7:0] nc_x;
  ostc_class_t   cl;
  logic          pop;

  assign pop     = q_valid_i && (!ov_q || m_axis_tready);
  assign q_pop_o = pop;
  assign cl      = q_item_i.cls;
  assign ends    = cl.slash | cl.gt;
  assign nbad    = cl.ctrl_nc | cl.sq | cl.dq;
  assign ubad    = nbad | cl.lt | cl.eq | cl.bq;

  always_comb begin
    ph   = ph_q;
    err  = err_q;
    qk   = qk_q;
    nc   = nc_q;
    ac   = ac_q;
    sl   = sl_q;
    role = RoleStruct;
    idx  = ac_q;

    unique case (ph_q)
      PhOpen: begin
        if (cl.lt) ph = PhNameFirst;
        else begin err = keep_first(err, ErrStart); ph = PhFailed; end
      end
      PhNameFirst, PhName: begin
        if (cl.alpha) begin
          role = RoleTagName;
          if (nc != NW'(MAX_NAME_LEN)) nc = nc + NW'(1);
          ph = PhName;
        end else if (ph_q == PhName && cl.ws) begin
          ph = PhGap;
        end else if (ph_q == PhName && ends) begin
          if (cl.slash) begin sl = 1'b1; ph = PhSlash; end
          else ph = PhClosed;
        end else begin
          err = keep_first(err, ErrName); ph = PhFailed;
        end
      end
      PhGap: begin
        if (cl.ws) begin
          ph = PhGap;
        end else if (ends) begin
          if (cl.slash) begin sl = 1'b1; ph = PhSlash; end
          else ph = PhClosed;
        end else if (cl.eq) begin
          ph = PhValStart;
        end else if (nbad) begin
          err = keep_first(err, ErrAttrName); ph = PhFailed;
        end else begin
          role = RoleAttrNm; ph = PhAttrName;
        end
      end
      PhAttrName: begin
        if (ends) begin
          if (ac != AW'(MAX_ATTRS)) ac = ac + AW'(1);
          if (cl.slash) begin sl = 1'b1; ph = PhSlash; end
          else ph = PhClosed;
        end else if (nbad) begin
          err = keep_first(err, ErrAttrName); ph = PhFailed;
        end else if (cl.space) begin
          ph = PhAfterName;
        end else if (cl.eq) begin
          ph = PhValStart;
        end else begin
          role = RoleAttrNm;
        end
      end
      PhAfterName: begin
        if (cl.ws) begin
          ph = PhAfterName;
        end else if (cl.eq) begin
          ph = PhValStart;
        end else if (ends) begin
          if (ac != AW'(MAX_ATTRS)) ac = ac + AW'(1);
          if (cl.slash) begin sl = 1'b1; ph = PhSlash; end
          else ph = PhClosed;
        end else begin
          // any other character closes this attribute and opens the next one
          if (ac != AW'(MAX_ATTRS)) ac = ac + AW'(1);
          idx = ac;
          if (nbad) begin err = keep_first(err, ErrAttrName); ph = PhFailed; end
          else begin role = RoleAttrNm; ph = PhAttrName; end
        end
      end
      PhValStart: begin
        if (cl.ws) begin
          ph = PhValStart;
        end else if (ends) begin
          err = keep_first(err, ErrNoValue); ph = PhFailed;
        end else if (cl.sq) begin
          qk = QkSingle; ph = PhQuoted;
        end else if (cl.dq) begin
          qk = QkDouble; ph = PhQuoted;
        end else if (ubad) begin
          err = keep_first(err, ErrValChar); ph = PhFailed;
        end else begin
          role = RoleAttrVal; ph = PhUnquoted;
        end
      end
      PhUnquoted: begin
        if (ends) begin
          if (ac != AW'(MAX_ATTRS)) ac = ac + AW'(1);
          if (cl.slash) begin sl = 1'b1; ph = PhSlash; end
          else ph = PhClosed;
        end else if (cl.space) begin
          if (ac != AW'(MAX_ATTRS)) ac = ac + AW'(1);
          ph = PhGap;
        end else if (ubad) begin
          err = keep_first(err, ErrValChar); ph = PhFailed;
        end else begin
          role = RoleAttrVal;
        end
      end
      PhQuoted: begin
        if (ends) begin
          err = keep_first(err, ErrUnclosed); ph = PhFailed;
        end else if ((qk == QkSingle && cl.sq) || (qk == QkDouble && cl.dq)) begin
          if (ac != AW'(MAX_ATTRS)) ac = ac + AW'(1);
          qk = QkNone; ph = PhGap;
        end else if (cl.ctrl_nc) begin
          err = keep_first(err, ErrValChar); ph = PhFailed;
        end else begin
          role = RoleAttrVal;
        end
      end
      PhSlash: begin
        if (cl.gt) ph = PhClosed;
        else begin err = keep_first(err, ErrSelfCl); ph = PhFailed; end
      end
      PhClosed: begin
        err = keep_first(err, ErrTrailing);
      end
      default: begin
        ph = PhFailed;
      end
    endcase

    // tag string ended before the closing bracket
    if (q_item_i.last && ph != PhClosed && ph != PhFailed) begin
      priority if (ph == PhNameFirst) err = keep_first(err, ErrName);
      else if (ph == PhValStart) err = keep_first(err, ErrNoValue);
      else if (ph == PhQuoted) err = keep_first(err, ErrUnclosed);
      else if (ph == PhSlash) err = keep_first(err, ErrSelfCl);
      else begin
        if ((ph == PhAttrName || ph == PhAfterName || ph == PhUnquoted) &&
            ac != AW'(MAX_ATTRS)) begin
          ac = ac + AW'(1);
        end
        err = keep_first(err, ErrNoEnd);
      end
      ph = PhFailed;
    end

    self_cl = sl && (ph == PhClosed);
    idx_x   = {6'b0, idx};
    ac_x    = {6'b0, ac};
    nc_x    = {8'b0, nc};
    data_d  = {5'b0, ac_x[5:0], nc_x[7:0], self_cl, err, idx_x[5:0], role};

    if (q_item_i.last) begin
      ph_d  = PhOpen;
      err_d = ErrNone;
      qk_d  = QkNone;
      nc_d  = '0;
      ac_d  = '0;
      sl_d  = 1'b0;
    end else begin
      ph_d  = ph;
      err_d = err;
      qk_d  = qk;
      nc_d  = nc;
      ac_d  = ac;
      sl_d  = sl;
    end

    ov_d = pop ? 1'b1 : (m_axis_tready ? 1'b0 : ov_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PhOpen;
      err_q <= ErrNone;
      qk_q  <= QkNone;
      nc_q  <= '0;
      ac_q  <= '0;
      sl_q  <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      ov_q <= ov_d;
      if (pop) begin
        ph_q  <= ph_d;
        err_q <= err_d;
        qk_q  <= qk_d;
        nc_q  <= nc_d;
        ac_q  <= ac_d;
        sl_q  <= sl_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      data_q <= data_d;
      last_q <= q_item_i.last;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tlast  = last_q;

  assign stat_o.pop  = pop;
  assign stat_o.last = q_item_i.last;
  assign stat_o.err  = err_q;

endmodule

FILE: rtl/core/opening_tag_syntax_checker.sv
// Start tag syntax checker. One code point goes in per word, one result word comes out for
// it: the character's role, its attribute number, the first error so far, the self-closing
// flag and the saturating name and attribute counts; tlast marks the tag's final character
// and its verdict. Throughput is one character per clock while m_axis_tready does not stall
// the output: the front end decodes the character class in the cycle it accepts the word and
// parks it in a two-entry queue, the back end advances the tag state machine one character
// per cycle into an output register. After the final character the checker returns to its
// start state, ready for the next tag with no gap.
module opening_tag_syntax_checker #(
  parameter int unsigned MAX_NAME_LEN = 255,
  parameter int unsigned MAX_ATTRS    = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // code_point[20:0], zero fill
  input  logic        s_axis_tlast,   // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // role[1:0], attr_number[7:2], error_code[11:8],
                                      // self_closing[12], name_length[20:13],
                                      // attr_count[26:21], zero fill
  output logic        m_axis_tlast    // done_res
);
  import ostc_pkg::*;

  logic       q_valid, q_pop;
  ostc_item_t q_item;
  ostc_stat_t stat;

  ostc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .q_valid_o    (q_valid),
    .q_item_o     (q_item),
    .q_pop_i      (q_pop)
  );

  ostc_back #(
    .MAX_NAME_LEN(MAX_NAME_LEN),
    .MAX_ATTRS   (MAX_ATTRS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .stat_o       (stat),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // the first error sticks until the tag ends
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.pop && !stat.last && stat.err != 4'd0 |=> stat.err == $past(stat.err))
    else $error("first error was overwritten");

  // a self-closed tag carries no error other than trailing characters
  a_self_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[12] |->
      m_axis_tdata[11:8] == 4'd0 || m_axis_tdata[11:8] == 4'd9)
    else $error("self-closing tag reported with an error");

  // error code stays within the defined codes
  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[11:8] <= 4'd9)
    else $error("undefined error code");

endmodule

FILE: bench/tb.sv
// testbench for the opening tag syntax checker: directed tags, then random tags checked by a predictor
`timescale 1ns / 100ps

module tb;

  localparam int unsigned MAX_NAME_LEN = 255;
  localparam int unsigned MAX_ATTRS    = 63;
  localparam int unsigned DIR_N        = 28;
  localparam int unsigned RANDOM_CHARS = 700;
  localparam int unsigned LONG_TAG     = 4;   // tag number that gets a name past saturation
  localparam int unsigned WIDE_TAG     = 9;   // tag number that gets more attributes than counted

  // character codes
  localparam logic [20:0] CH_TAB   = 21'h09;
  localparam logic [20:0] CH_CR    = 21'h0D;
  localparam logic [20:0] CH_SP    = 21'h20;
  localparam logic [20:0] CH_DQ    = 21'h22;
  localparam logic [20:0] CH_SQ    = 21'h27;
  localparam logic [20:0] CH_SLASH = 21'h2F;
  localparam logic [20:0] CH_LT    = 21'h3C;
  localparam logic [20:0] CH_EQ    = 21'h3D;
  localparam logic [20:0] CH_GT    = 21'h3E;
  localparam logic [20:0] CH_BQ    = 21'h60;
  localparam logic [20:0] CH_UA    = 21'h41;
  localparam logic [20:0] CH_UZ    = 21'h5A;
  localparam logic [20:0] CH_LA    = 21'h61;
  localparam logic [20:0] CH_LZ    = 21'h7A;
  localparam logic [20:0] CH_MAX   = 21'h10FFFF;

  localparam logic [3:0] E_NONE       = 4'd0;
  localparam logic [3:0] E_START      = 4'd1;
  localparam logic [3:0] E_NAME       = 4'd2;
  localparam logic [3:0] E_ATTR_NAME  = 4'd3;
  localparam logic [3:0] E_NO_VALUE   = 4'd4;
  localparam logic [3:0] E_VALUE_CHAR = 4'd5;
  localparam logic [3:0] E_OPEN_QUOTE = 4'd6;
  localparam logic [3:0] E_NO_END     = 4'd7;
  localparam logic [3:0] E_SELF_CLOSE = 4'd8;
  localparam logic [3:0] E_TRAILING   = 4'd9;

  localparam logic [1:0] R_STRUCT     = 2'd0;
  localparam logic [1:0] R_TAG_NAME   = 2'd1;
  localparam logic [1:0] R_ATTR_NAME  = 2'd2;
  localparam logic [1:0] R_ATTR_VALUE = 2'd3;

  localparam logic [1:0] Q_NONE   = 2'd0;
  localparam logic [1:0] Q_SINGLE = 2'd1;
  localparam logic [1:0] Q_DOUBLE = 2'd2;

  typedef enum logic [3:0] {
    ST_OPEN, ST_NAME_FIRST, ST_NAME, ST_GAP, ST_ATTR_NAME, ST_AFTER_NAME,
    ST_VAL_START, ST_UNQUOTED, ST_QUOTED, ST_SLASH, ST_CLOSED, ST_FAILED
  } tag_phase_e;

  // laid out as the output word, lowest field last
  typedef struct packed {
    logic [4:0] fill;
    logic [5:0] acnt;
    logic [7:0] nlen;
    logic       sc;
    logic [3:0] err;
    logic [5:0] idx;
    logic [1:0] role;
  } tag_word_t;

  typedef struct packed {
    logic      done;
    tag_word_t w;
  } tag_res_t;

  typedef struct packed {
    logic [20:0] cp;
    logic        last;
    logic        pin;
    tag_word_t   word;
  } dir_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  // predictor state
  tag_phase_e  ph;
  logic [3:0]  first_err;
  logic [1:0]  quote;
  logic [7:0]  name_len;
  logic [5:0]  attrs;
  logic        slash;

  tag_res_t    char_results_q[$];
  logic [20:0] tag_chars[$];
  dir_row_t    dir_rows[DIR_N];
  int          mismatches  = 0;
  int unsigned chars_sent  = 0;
  int unsigned words_seen  = 0;

  opening_tag_syntax_checker #(
    .MAX_NAME_LEN(MAX_NAME_LEN),
    .MAX_ATTRS   (MAX_ATTRS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // code_point[20:0], zero fill
    .s_axis_tlast (s_axis_tlast),   // is_last
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // role, attr_number, error_code, self_closing,
                                    // name_length, attr_count, zero fill
    .m_axis_tlast (m_axis_tlast)    // done_res
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic is_ws(logic [20:0] c);
    return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic ends_region(logic [20:0] c);
    return c == CH_SLASH || c == CH_GT;
  endfunction

  function automatic logic ctrl_nc(logic [20:0] c);
    return c < CH_SP || (c >= 21'h7F && c <= 21'h9F) || c > CH_MAX ||
           (c >= 21'hFDD0 && c <= 21'hFDEF) || (&c[15:1]);
  endfunction

  function automatic logic name_bad(logic [20:0] c);
    return ctrl_nc(c) || c == CH_DQ || c == CH_SQ;
  endfunction

  function automatic logic unq_bad(logic [20:0] c);
    return name_bad(c) || c == CH_LT || c == CH_EQ || c == CH_BQ;
  endfunction

  function automatic void clear_tag();
    ph        = ST_OPEN;
    first_err = E_NONE;
    quote     = Q_NONE;
    name_len  = '0;
    attrs     = '0;
    slash     = 1'b0;
  endfunction

  function automatic void raise_error(logic [3:0] code);
    if (first_err == E_NONE) first_err = code;
    ph = ST_FAILED;
  endfunction

  function automatic void close_attr();
    if (attrs < MAX_ATTRS) attrs++;
  endfunction

  function automatic void end_region(logic [20:0] c);
    if (c == CH_SLASH) begin
      slash = 1'b1;
      ph    = ST_SLASH;
    end else begin
      ph = ST_CLOSED;
    end
  endfunction

  function automatic logic [1:0] open_attr_name(logic [20:0] c);
    if (name_bad(c)) begin
      raise_error(E_ATTR_NAME);
      return R_STRUCT;
    end
    ph = ST_ATTR_NAME;
    return R_ATTR_NAME;
  endfunction

  function automatic tag_res_t classify_char(logic [20:0] c, logic last);
    tag_res_t   r;
    logic [1:0] role;
    logic [5:0] idx;
    role = R_STRUCT;
    idx  = attrs;
    case (ph)
      ST_OPEN: begin
        if (c == CH_LT) ph = ST_NAME_FIRST;
        else raise_error(E_START);
      end
      ST_NAME_FIRST, ST_NAME: begin
        if ((c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ)) begin
          role = R_TAG_NAME;
          if (name_len < MAX_NAME_LEN) name_len++;
          ph = ST_NAME;
        end else if (ph == ST_NAME && is_ws(c)) begin
          ph = ST_GAP;
        end else if (ph == ST_NAME && ends_region(c)) begin
          end_region(c);
        end else begin
          raise_error(E_NAME);
        end
      end
      ST_GAP: begin
        if (!is_ws(c)) begin
          if (ends_region(c)) end_region(c);
          else if (c == CH_EQ) ph = ST_VAL_START;
          else role = open_attr_name(c);
        end
      end
      ST_ATTR_NAME: begin
        if (ends_region(c)) begin
          close_attr();
          end_region(c);
        end else if (name_bad(c)) begin
          raise_error(E_ATTR_NAME);
        end else if (c == CH_SP) begin
          ph = ST_AFTER_NAME;
        end else if (c == CH_EQ) begin
          ph = ST_VAL_START;
        end else begin
          role = R_ATTR_NAME;
        end
      end
      ST_AFTER_NAME: begin
        if (!is_ws(c)) begin
          if (c == CH_EQ) begin
            ph = ST_VAL_START;
          end else if (ends_region(c)) begin
            close_attr();
            end_region(c);
          end else begin
            // anything else finishes the bare name and opens the next attribute
            close_attr();
            idx  = attrs;
            role = open_attr_name(c);
          end
        end
      end
      ST_VAL_START: begin
        if (!is_ws(c)) begin
          if (ends_region(c)) begin
            raise_error(E_NO_VALUE);
          end else if (c == CH_SQ) begin
            quote = Q_SINGLE;
            ph    = ST_QUOTED;
          end else if (c == CH_DQ) begin
            quote = Q_DOUBLE;
            ph    = ST_QUOTED;
          end else if (unq_bad(c)) begin
            raise_error(E_VALUE_CHAR);
          end else begin
            role = R_ATTR_VALUE;
            ph   = ST_UNQUOTED;
          end
        end
      end
      ST_UNQUOTED: begin
        if (ends_region(c)) begin
          close_attr();
          end_region(c);
        end else if (c == CH_SP) begin
          close_attr();
          ph = ST_GAP;
        end else if (unq_bad(c)) begin
          raise_error(E_VALUE_CHAR);
        end else begin
          role = R_ATTR_VALUE;
        end
      end
      ST_QUOTED: begin
        if (ends_region(c)) begin
          raise_error(E_OPEN_QUOTE);
        end else if ((quote == Q_SINGLE && c == CH_SQ) || (quote == Q_DOUBLE && c == CH_DQ)) begin
          close_attr();
          quote = Q_NONE;
          ph    = ST_GAP;
        end else if (ctrl_nc(c)) begin
          raise_error(E_VALUE_CHAR);
        end else begin
          role = R_ATTR_VALUE;
        end
      end
      ST_SLASH: begin
        if (c == CH_GT) ph = ST_CLOSED;
        else raise_error(E_SELF_CLOSE);
      end
      ST_CLOSED: begin
        if (first_err == E_NONE) first_err = E_TRAILING;
      end
      default: ph = ST_FAILED;
    endcase

    // tag cut short: verdict depends on where it stopped
    if (last && ph != ST_CLOSED && ph != ST_FAILED) begin
      case (ph)
        ST_NAME_FIRST: raise_error(E_NAME);
        ST_VAL_START:  raise_error(E_NO_VALUE);
        ST_QUOTED:     raise_error(E_OPEN_QUOTE);
        ST_SLASH:      raise_error(E_SELF_CLOSE);
        default: begin
          if (ph == ST_ATTR_NAME || ph == ST_AFTER_NAME || ph == ST_UNQUOTED) close_attr();
          raise_error(E_NO_END);
        end
      endcase
    end

    r.done   = last;
    r.w.fill = '0;
    r.w.acnt = attrs;
    r.w.nlen = name_len;
    r.w.sc   = slash && ph == ST_CLOSED;
    r.w.err  = first_err;
    r.w.idx  = idx;
    r.w.role = role;
    if (last) clear_tag();
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic tag_word_t pin_word(logic [3:0] err, logic [7:0] nlen);
    tag_word_t w;
    w      = '0;
    w.err  = err;
    w.nlen = nlen;
    return w;
  endfunction

  function automatic logic [20:0] letter();
    logic [20:0] r;
    r = 21'($urandom_range(0, 25));
    return ($urandom_range(0, 1) != 0) ? CH_UA + r : CH_LA + r;
  endfunction

  function automatic logic [20:0] ws_char();
    if ($urandom_range(0, 1) != 0) return CH_SP;
    return 21'($urandom_range(CH_TAB, CH_CR));
  endfunction

  // characters meant for names and values; the top range can also give a noncharacter such as 1FFFE
  function automatic logic [20:0] plain_char();
    case ($urandom_range(0, 3))
      0:       return letter();
      1:       return 21'($urandom_range(21'h30, 21'h39));
      2:       return 21'($urandom_range(21'hA0, 21'hFDCF));
      default: return 21'($urandom_range(21'h10000, 21'h10FFFD));
    endcase
  endfunction

  function automatic logic [20:0] wild_char();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 7))
          0:       return CH_LT;
          1:       return CH_GT;
          2:       return CH_SLASH;
          3:       return CH_EQ;
          4:       return CH_SQ;
          5:       return CH_DQ;
          6:       return CH_BQ;
          default: return CH_SP;
        endcase
      end
      1:       return ws_char();
      2:       return 21'($urandom_range(0, 21'h1F));
      3:       return 21'($urandom_range(21'h7F, 21'h9F));
      4:       return 21'($urandom_range(21'hFDD0, 21'hFDEF));
      5:       return (21'($urandom_range(0, 16)) << 16) | 21'hFFFE | 21'($urandom_range(0, 1));
      6:       return letter();
      default: return 21'($urandom_range(0, CH_MAX));
    endcase
  endfunction

  // mostly well formed tags with random content, some broken, some pure noise
  task automatic build_tag(int unsigned tag_no);
    int unsigned n;
    int unsigned vk;
    int unsigned pos;
    logic        loose;
    logic [20:0] q;
    tag_chars.delete();
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 6)) tag_chars.push_back(wild_char());
      return;
    end
    tag_chars.push_back(CH_LT);
    if (tag_no == LONG_TAG) n = 260;
    else if ($urandom_range(0, 15) == 0) n = 0;
    else n = $urandom_range(1, 6);
    repeat (n) tag_chars.push_back(letter());
    loose = 1'b1;  // any whitespace may follow the tag name or a closing quote
    repeat ((tag_no == WIDE_TAG) ? 66 : $urandom_range(0, 4)) begin
      tag_chars.push_back((loose && $urandom_range(0, 2) == 0) ? ws_char() : CH_SP);
      if (tag_no == WIDE_TAG) begin
        tag_chars.push_back(letter());
        loose = 1'b0;
      end else begin
        n = $urandom_range(0, 3);
        repeat (n) tag_chars.push_back(plain_char());
        vk = $urandom_range(0, 3);
        if (n == 0 && vk == 0) vk = 1;
        loose = 1'b0;
        if (vk != 0) begin
          if (n != 0 && $urandom_range(0, 3) == 0) tag_chars.push_back(CH_SP);
          tag_chars.push_back(CH_EQ);
          if ($urandom_range(0, 3) == 0) tag_chars.push_back(ws_char());
          if (vk == 1) begin
            repeat ($urandom_range(1, 3)) tag_chars.push_back(plain_char());
          end else begin
            q = (vk == 2) ? CH_SQ : CH_DQ;
            tag_chars.push_back(q);
            repeat ($urandom_range(0, 3)) begin
              case ($urandom_range(0, 3))
                0:       tag_chars.push_back(CH_SP);
                1:       tag_chars.push_back((q == CH_SQ) ? CH_DQ : CH_SQ);
                2:       tag_chars.push_back($urandom_range(0, 1) ? CH_LT : CH_BQ);
                default: tag_chars.push_back(plain_char());
              endcase
            end
            tag_chars.push_back(q);
            loose = 1'b1;
          end
        end
      end
    end
    if ($urandom_range(0, 1) != 0) tag_chars.push_back(CH_SLASH);
    tag_chars.push_back(CH_GT);

    pos = $urandom_range(0, tag_chars.size() - 1);
    case ($urandom_range(0, 9))
      0: tag_chars[pos] = wild_char();
      1: while (tag_chars.size() > pos + 1) void'(tag_chars.pop_back());
      2: repeat ($urandom_range(1, 3)) tag_chars.push_back(wild_char());
      3: tag_chars.insert(pos, wild_char());
      default: ;
    endcase
  endtask

  task automatic send_char(logic [20:0] c, logic last);
    int unsigned gap;
    gap = ((chars_sent / 40) % 3 == 1) ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, c};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    chars_sent++;
  endtask

  task automatic feed_char(logic [20:0] c, logic last, logic pin, tag_word_t pinned);
    tag_res_t r;
    send_char(c, last);
    r = classify_char(c, last);
    if (pin) begin
      r.done = last;
      r.w    = pinned;
    end
    char_results_q.push_back(r);
  endtask

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  // ---------------------------------------------------------------- result side

  initial begin
    tag_res_t    want;
    tag_res_t    got;
    int unsigned stall;
    wait (rst_ni);
    forever begin
      stall = ((words_seen / 55) % 3 == 2) ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      words_seen++;
      got.done = m_axis_tlast;
      got.w    = m_axis_tdata;
      if (char_results_q.size() == 0) begin
        mismatches++;
        $display("%0t word mismatch: expected nothing, actual %h", $time, m_axis_tdata);
      end else begin
        want = char_results_q.pop_front();
        check_field("role", want.w.role, got.w.role);
        check_field("attr_number", want.w.idx, got.w.idx);
        check_field("error_code", want.w.err, got.w.err);
        check_field("done", want.done, got.done);
        check_field("self_closing", want.w.sc, got.w.sc);
        check_field("name_length", want.w.nlen, got.w.nlen);
        check_field("attr_count", want.w.acnt, got.w.acnt);
        check_field("fill", want.w.fill, got.w.fill);
      end
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    int unsigned tag_no;
    int unsigned random_sent;
    clear_tag();
    // broken tags, a self-closing tag with unquoted and quoted values, a tag with trailing text
    dir_rows = '{
      '{21'd0,    1'b1, 1'b1, pin_word(E_START, 8'd0)},
      '{CH_LT,    1'b0, 1'b1, pin_word(E_NONE, 8'd0)},
      '{CH_LT,    1'b1, 1'b1, pin_word(E_NAME, 8'd0)},
      '{CH_LT,    1'b0, 1'b0, '0},
      '{"a",      1'b0, 1'b0, '0},
      '{CH_SP,    1'b0, 1'b0, '0},
      '{"b",      1'b0, 1'b0, '0},
      '{CH_EQ,    1'b0, 1'b0, '0},
      '{"c",      1'b0, 1'b0, '0},
      '{CH_SP,    1'b0, 1'b0, '0},
      '{"d",      1'b0, 1'b0, '0},
      '{CH_EQ,    1'b0, 1'b0, '0},
      '{CH_SQ,    1'b0, 1'b0, '0},
      '{"e",      1'b0, 1'b0, '0},
      '{CH_SQ,    1'b0, 1'b0, '0},
      '{CH_SP,    1'b0, 1'b0, '0},
      '{CH_EQ,    1'b0, 1'b0, '0},
      '{"h",      1'b0, 1'b0, '0},
      '{CH_SP,    1'b0, 1'b0, '0},
      '{"i",      1'b0, 1'b0, '0},
      '{CH_SP,    1'b0, 1'b0, '0},
      '{"j",      1'b0, 1'b0, '0},
      '{CH_SLASH, 1'b0, 1'b0, '0},
      '{CH_GT,    1'b1, 1'b0, '0},
      '{CH_LT,    1'b0, 1'b0, '0},
      '{"a",      1'b0, 1'b0, '0},
      '{CH_GT,    1'b0, 1'b0, '0},
      '{CH_MAX,   1'b1, 1'b1, pin_word(E_TRAILING, 8'd1)}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_N; i++)
      feed_char(dir_rows[i].cp, dir_rows[i].last, dir_rows[i].pin, dir_rows[i].word);

    tag_no      = 0;
    random_sent = 0;
    while (random_sent < RANDOM_CHARS) begin
      build_tag(tag_no);
      for (int i = 0; i < tag_chars.size(); i++)
        feed_char(tag_chars[i], i == tag_chars.size() - 1, 1'b0, '0);
      random_sent += tag_chars.size();
      tag_no++;
    end
    s_axis_tvalid <= 1'b0;

    while (char_results_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && char_results_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: opening_tag_syntax_checker.f
rtl/core/ostc_pkg.sv
rtl/core/ostc_front.sv
rtl/core/ostc_back.sv
rtl/core/opening_tag_syntax_checker.sv
bench/tb.sv
